FILE: hw/rtl/rdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rdp_pkg;
  localparam logic [30:0] PM_MOD = 31'h7FFFFFFF;
  localparam logic [14:0] PM_MUL = 15'd16807;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  localparam logic [2:0] REG_BOND = 3'd0;
  localparam logic [2:0] REG_XX = 3'd1;
  localparam logic [2:0] REG_YX = 3'd2;
  localparam logic [2:0] REG_ZX = 3'd3;
  localparam logic [2:0] REG_YY = 3'd4;
  localparam logic [2:0] REG_ZY = 3'd5;
  localparam logic [2:0] REG_ZZ = 3'd6;
  localparam logic [2:0] REG_SEED = 3'd7;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h3243F6A8;
      5'd1: t = 32'h1DAC6705;
      5'd2: t = 32'h0FADBAFC;
      5'd3: t = 32'h07F56EA6;
      5'd4: t = 32'h03FEAB76;
      5'd5: t = 32'h01FFD55B;
      5'd6: t = 32'h00FFFAAA;
      5'd7: t = 32'h007FFF55;
      5'd8: t = 32'h003FFFEA;
      5'd9: t = 32'h001FFFFD;
      5'd31: t = 32'h0;
      default: t = 32'h40000000 >> i;
    endcase
    return $signed(t);
  endfunction

  // one multiply request to the shared unit
  typedef struct packed {
    logic signed [33:0] a;
    logic signed [33:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rdp_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative rotation CORDIC: one micro-rotation per cycle.
module rdp_cordic #(
  parameter int STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [33:0] z0,
  output logic                    done,
  output logic signed [33:0]      xo,
  output logic signed [33:0]      yo
);
  localparam int CW = $clog2(STEPS + 1);
  logic [CW-1:0] i;
  logic          busy;
  logic signed [33:0] z;
  logic signed [33:0] dx, dy, at;
  logic [4:0] i5;

  assign i5 = 5'(i);
  assign dx = yo >>> i;
  assign dy = xo >>> i;
  assign at = 34'(rdp_pkg::atan_q30(i5));

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (i == CW'(STEPS));
    if (rst) begin
      busy <= 1'b0;
      i <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i <= '0;
      z <= z0;
      xo <= 34'(signed'(rdp_pkg::GAIN_Q30));
      yo <= '0;
    end else if (busy) begin
      if (i == CW'(STEPS)) begin
        busy <= 1'b0;
      end else begin
        i <= i + 1'b1;
        if (!z[33]) begin
          xo <= xo - dx; yo <= yo + dy; z <= z - at;
        end else begin
          xo <= xo + dx; yo <= yo - dy; z <= z + at;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/random_dimer_placer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Random dimer placer. Each accepted request places one two-atom molecule:
// a Park-Miller generator (16807, 2^31-1) is stepped five times, one step per
// cycle, the first three uniforms give the first atom (Q0.32), the last two give
// polar and azimuth angles. Two CORDIC passes of CORDIC_STEPS iterations each
// produce sines and cosines; a single shared 34x34 multiplier (one product a
// cycle, registered) then forms the bond vector and maps it through the cell
// matrix, each bond component split in two halves, and the sums are wrapped
// into [0,1). The result is built in order: the generator steps, two CORDIC
// passes, the multiply sequence and one output load. in_ready is low meanwhile
// and comes back once the result is loaded. A finished result waits in S_OUT
// until the output register is free, which holds off the next request.
// Registers must be written through cfg_we/cfg_addr/cfg_data only while idle;
// the block itself does not enforce this.
module random_dimer_placer_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        reseed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      first_x,
  output logic [31:0]      first_y,
  output logic [31:0]      first_z,
  output logic [31:0]      second_x,
  output logic [31:0]      second_y,
  output logic [31:0]      second_z
);
  typedef enum logic [3:0] {
    S_IDLE, S_RNG, S_ANG, S_COR, S_CWAIT, S_MUL, S_OUT
  } state_t;

  state_t state;
  logic [31:0] bond_length;
  logic [31:0] cmat [6];
  logic [30:0] start_seed;
  logic [30:0] gen;
  logic [2:0]  cnt;
  logic [31:0] fx, fy, fz;
  logic [30:0] ph;
  logic [31:0] th;
  logic        pass;     // 0: polar angle, 1: azimuth
  logic [1:0]  quad;
  logic signed [33:0] cp, sp, ct, st;
  logic signed [33:0] ux, uy;   // direction products, Q4.30
  logic signed [39:0] vx, vy, vz;
  logic [63:0] dx, dy, dz;
  logic [4:0]  mstep;

  // generator step (Schrage form reduces to this Mersenne fold)
  logic [45:0] prod;
  logic [31:0] fold;
  logic [30:0] gen_next;
  assign prod = 46'(gen) * 46'(rdp_pkg::PM_MUL);
  assign fold = 32'(prod[30:0]) + 32'(prod[45:31]);
  always_comb begin
    gen_next = fold[31] ? 31'(fold[30:0] + 31'd1) : fold[30:0];
    // a zero state steps to the modulus, which then maps to itself
    if (gen_next == '0) gen_next = rdp_pkg::PM_MOD;
  end

  // angle reduction
  logic [31:0] ang, sh;
  logic signed [30:0] res;
  logic signed [63:0] zprod;
  logic signed [33:0] z0;
  logic cstart, cdone;
  logic signed [33:0] cx, cy, co, si;
  assign ang = pass ? th : {1'b0, ph};
  assign sh = ang + 32'h20000000;
  assign res = $signed({1'b0, sh[29:0]}) - 31'sh20000000;
  assign zprod = 64'(res) * 64'(signed'({1'b0, rdp_pkg::HALF_PI_Q30}));
  assign z0 = 34'(zprod >>> 30);

  rdp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cstart), .z0, .done(cdone), .xo(cx), .yo(cy)
  );

  always_comb begin
    case (quad)
      2'd0: begin co = cx;  si = cy;  end
      2'd1: begin co = -cy; si = cx;  end
      2'd2: begin co = -cx; si = -cy; end
      default: begin co = cy; si = -cx; end
    endcase
  end

  // shared multiplier: one product per cycle, registered
  rdp_pkg::mul_req_t mreq;
  logic signed [67:0] mprod, mres;
  logic signed [33:0] bl, c0, c1, c2, c3, c4, c5;
  // bond components as low 20 bits and signed high part
  logic signed [33:0] vx_lo, vx_hi, vy_lo, vy_hi, vz_lo, vz_hi;
  assign bl = 34'(signed'({1'b0, bond_length}));
  assign c0 = 34'(signed'(cmat[0]));
  assign c1 = 34'(signed'(cmat[1]));
  assign c2 = 34'(signed'(cmat[2]));
  assign c3 = 34'(signed'(cmat[3]));
  assign c4 = 34'(signed'(cmat[4]));
  assign c5 = 34'(signed'(cmat[5]));
  assign vx_lo = $signed({14'd0, vx[19:0]});
  assign vy_lo = $signed({14'd0, vy[19:0]});
  assign vz_lo = $signed({14'd0, vz[19:0]});
  assign vx_hi = 34'(vx >>> 20);
  assign vy_hi = 34'(vy >>> 20);
  assign vz_hi = 34'(vz >>> 20);

  always_comb begin
    mreq.a = ct; mreq.b = sp;
    case (mstep)
      5'd0: begin mreq.a = ct; mreq.b = sp; end
      5'd1: begin mreq.a = st; mreq.b = sp; end
      5'd2: begin mreq.a = cp; mreq.b = bl; end
      5'd3: begin mreq.a = ux; mreq.b = bl; end
      5'd4: begin mreq.a = uy; mreq.b = bl; end
      5'd5: begin mreq.a = vz_lo; mreq.b = c2; end
      5'd6: begin mreq.a = vz_hi; mreq.b = c2; end
      5'd7: begin mreq.a = vx_lo; mreq.b = c0; end
      5'd8: begin mreq.a = vx_hi; mreq.b = c0; end
      5'd9: begin mreq.a = vy_lo; mreq.b = c1; end
      5'd10: begin mreq.a = vy_hi; mreq.b = c1; end
      5'd11: begin mreq.a = vy_lo; mreq.b = c3; end
      5'd12: begin mreq.a = vy_hi; mreq.b = c3; end
      5'd13: begin mreq.a = vz_lo; mreq.b = c4; end
      5'd14: begin mreq.a = vz_hi; mreq.b = c4; end
      5'd15: begin mreq.a = vz_lo; mreq.b = c5; end
      5'd16: begin mreq.a = vz_hi; mreq.b = c5; end
      default: ;
    endcase
  end
  assign mprod = 68'(mreq.a) * 68'(mreq.b);

  always_ff @(posedge clk) begin
    cstart <= !rst && (state == S_ANG);
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      bond_length <= 32'd16777216;
      cmat[0] <= 32'd16777216; cmat[1] <= '0; cmat[2] <= '0;
      cmat[3] <= 32'd16777216; cmat[4] <= '0; cmat[5] <= 32'd16777216;
      start_seed <= 31'd1;
      gen <= 31'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rdp_pkg::REG_BOND: bond_length <= cfg_data;
          rdp_pkg::REG_XX: cmat[0] <= cfg_data;
          rdp_pkg::REG_YX: cmat[1] <= cfg_data;
          rdp_pkg::REG_ZX: cmat[2] <= cfg_data;
          rdp_pkg::REG_YY: cmat[3] <= cfg_data;
          rdp_pkg::REG_ZY: cmat[4] <= cfg_data;
          rdp_pkg::REG_ZZ: cmat[5] <= cfg_data;
          rdp_pkg::REG_SEED: start_seed <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          if (reseed) gen <= start_seed;
          cnt <= '0;
          state <= S_RNG;
        end
        S_RNG: begin
          gen <= gen_next;
          cnt <= cnt + 1'b1;
          case (cnt)
            3'd0: fx <= {gen_next, 1'b0};
            3'd1: fy <= {gen_next, 1'b0};
            3'd2: fz <= {gen_next, 1'b0};
            3'd3: ph <= gen_next;
            default: begin th <= {gen_next, 1'b0}; pass <= 1'b0; state <= S_ANG; end
          endcase
        end
        S_ANG: begin
          quad <= sh[31:30];
          state <= S_COR;
        end
        S_COR: state <= S_CWAIT;
        S_CWAIT: if (cdone) begin
          if (!pass) begin
            cp <= co; sp <= si; pass <= 1'b1; state <= S_ANG;
          end else begin
            ct <= co; st <= si; mstep <= '0;
            dx <= '0; dy <= '0; dz <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // mres holds the product issued on the previous step
          mres <= mprod;
          mstep <= mstep + 1'b1;
          case (mstep)
            5'd1: ux <= 34'(mres >>> 30);
            5'd2: uy <= 34'(mres >>> 30);
            5'd3: vz <= 40'(mres >>> 24);
            5'd4: vx <= 40'(mres >>> 24);
            5'd5: vy <= 40'(mres >>> 24);
            5'd6, 5'd8, 5'd10: dx <= dx + 64'(mres);
            5'd7, 5'd9, 5'd11: dx <= dx + (64'(mres) << 20);
            5'd12, 5'd14: dy <= dy + 64'(mres);
            5'd13, 5'd15: dy <= dy + (64'(mres) << 20);
            5'd16: dz <= dz + 64'(mres);
            5'd17: begin dz <= dz + (64'(mres) << 20); state <= S_OUT; end
            default: ;
          endcase
        end
        S_OUT: if (!out_valid || out_ready) begin
          first_x <= fx; first_y <= fy; first_z <= fz;
          second_x <= fx + dx[53:22];
          second_y <= fy + dy[53:22];
          second_z <= fz + dz[53:22];
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
endmodule
`default_nettype wire

FILE: hw/rtl/rdp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rdp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] first_x
);
  // no new request while working
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  // result waits until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_x)) else $error("result dropped");
  // no result right after an accept
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid) else $error("early result");
  // first coordinate is an even uniform
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !first_x[0]) else $error("odd coordinate");
endmodule

bind random_dimer_placer_top rdp_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .first_x
);
`default_nettype wire

FILE: tb/sv/dimer_checker.sv
`timescale 1ns / 1ps
module dimer_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        reseed,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] first_x,
  input  logic [31:0] first_y,
  input  logic [31:0] first_z,
  input  logic [31:0] second_x,
  input  logic [31:0] second_y,
  input  logic [31:0] second_z,
  output int          errors,
  output int          pending
);
  typedef struct {
    logic [31:0] pos [6];
  } placement_t;

  localparam longint PM_Q = 127773;
  localparam longint PM_R = 2836;
  localparam longint MODV = 64'd2147483647;

  longint atan_tab [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h00100000, 'h00080000,
    'h00040000, 'h00020000, 'h00010000, 'h00008000, 'h00004000, 'h00002000,
    'h00001000, 'h00000800, 'h00000400, 'h00000200, 'h00000100, 'h00000080,
    'h00000040, 'h00000020, 'h00000010, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000};

  logic [31:0] bond;
  logic [31:0] cmat [6];   // xx yx zx yy zy zz
  logic [30:0] seed_reg;
  logic [30:0] gen;
  placement_t  placements [$];

  function automatic logic [30:0] pm_next(input logic [30:0] s);
    longint sv, r;
    sv = longint'(s);
    r = 16807 * (sv % PM_Q) - PM_R * (sv / PM_Q);
    if (r <= 0) r += MODV;
    return r[30:0];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
    logic [31:0] sh;
    longint r, z, x, y, dx, dy;
    sh = ang + 32'h20000000;
    r = longint'(sh[29:0]) - 64'sh20000000;
    z = (r * longint'(rdp_pkg::HALF_PI_Q30)) >>> 30;
    x = longint'(rdp_pkg::GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (sh[31:30])
      2'd0: begin co = x; si = y; end
      2'd1: begin co = -y; si = x; end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic place_dimer(input logic rs, output placement_t p);
    logic [31:0] f [3];
    logic [31:0] ph, th;
    longint cp, sp, ct, st, vx, vy, vz;
    logic [63:0] dx, dy, dz;
    if (rs) gen = seed_reg;
    for (int i = 0; i < 3; i++) begin
      gen = pm_next(gen);
      f[i] = {gen, 1'b0};
    end
    gen = pm_next(gen);
    ph = {1'b0, gen};
    gen = pm_next(gen);
    th = {gen, 1'b0};
    rotate(ph, cp, sp);
    rotate(th, ct, st);
    vx = (((ct * sp) >>> 30) * longint'({32'd0, bond})) >>> 24;
    vy = (((st * sp) >>> 30) * longint'({32'd0, bond})) >>> 24;
    vz = (cp * longint'({32'd0, bond})) >>> 24;
    dx = sx(cmat[0]) * vx + sx(cmat[1]) * vy + sx(cmat[2]) * vz;
    dy = sx(cmat[3]) * vy + sx(cmat[4]) * vz;
    dz = sx(cmat[5]) * vz;
    p.pos[0] = f[0];
    p.pos[1] = f[1];
    p.pos[2] = f[2];
    p.pos[3] = f[0] + dx[53:22];
    p.pos[4] = f[1] + dy[53:22];
    p.pos[5] = f[2] + dz[53:22];
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    placement_t p;
    logic [31:0] got [6];
    string names [6] = '{"first_x", "first_y", "first_z",
                         "second_x", "second_y", "second_z"};
    if (rst) begin
      bond = 32'h01000000;
      cmat = '{32'h01000000, 0, 0, 32'h01000000, 0, 32'h01000000};
      seed_reg = 31'd1;
      gen = 31'd1;
      placements.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rdp_pkg::REG_BOND: bond = cfg_data;
          rdp_pkg::REG_SEED: seed_reg = cfg_data[30:0];
          default: cmat[cfg_addr - rdp_pkg::REG_XX] = cfg_data;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{first_x, first_y, first_z, second_x, second_y, second_z};
        if (placements.size() == 0) begin
          report("unexpected placement", first_x, 32'hx);
        end else begin
          p = placements.pop_front();
          for (int i = 0; i < 6; i++)
            if (got[i] !== p.pos[i]) report(names[i], got[i], p.pos[i]);
        end
      end
      if (in_valid && in_ready) begin
        place_dimer(reseed, p);
        placements.push_back(p);
      end
      pending = placements.size();
    end
  end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, reseed;
  logic out_valid, out_ready;
  logic [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
  int errors, pending;
  bit long_hold;   // asks the receiver for one long stall
  bit burst;       // no idle on either side while set

  random_dimer_placer_top DUT (.*);

  dimer_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #30ms;
    $display("random_dimer_placer_top verification failed");
    $finish;
  end

  // receiver: random stall per request, or one long hold on demand
  initial begin
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready = 0;
        repeat (600) @(negedge clk);
        long_hold = 0;
      end else if (!burst) begin
        out_ready = 0;
        repeat ($urandom_range(16)) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // block is idle once every placement is back; a little margin on top
  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send(input logic rs);
    if (!burst) repeat ($urandom_range(16)) @(negedge clk);
    in_valid = 1;
    reseed = rs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    reseed = $urandom_range(1);
  endtask

  function automatic logic [31:0] pick_cell(input int mode);
    case (mode)
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom;
      default: return $urandom_range(32'h04000000) - 32'h02000000;  // within +-2.0
    endcase
  endfunction

  initial begin
    int mode;
    rst = 1;
    cfg_we = 0; cfg_addr = rdp_pkg::REG_BOND; cfg_data = 0;
    in_valid = 0; reseed = 0;
    long_hold = 0; burst = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset settings, then reseed, then seed corner values
    for (int i = 0; i < 4; i++) send(i == 2);
    burst = 1;
    for (int i = 0; i < 4; i++) send(0);
    burst = 0;
    drain();
    write_reg(rdp_pkg::REG_SEED, 32'h0);          // zero seed folds to modulus
    send(1); send(0);
    drain();
    write_reg(rdp_pkg::REG_SEED, 32'h7FFFFFFF);   // fixed point of the generator
    send(1); send(0);
    drain();
    write_reg(rdp_pkg::REG_BOND, 32'hFFFFFFFF);
    write_reg(rdp_pkg::REG_XX, 32'h80000000); write_reg(rdp_pkg::REG_YX, 32'h7FFFFFFF);
    write_reg(rdp_pkg::REG_ZX, 32'h80000000); write_reg(rdp_pkg::REG_YY, 32'h7FFFFFFF);
    write_reg(rdp_pkg::REG_ZY, 32'h80000000); write_reg(rdp_pkg::REG_ZZ, 32'h7FFFFFFF);
    write_reg(rdp_pkg::REG_SEED, 32'h12345678);
    send(1); send(0); send(0);
    drain();
    write_reg(rdp_pkg::REG_BOND, 32'h0);
    for (int r = rdp_pkg::REG_XX; r <= rdp_pkg::REG_ZZ; r++) write_reg(r[2:0], 32'hFFFFFFFF);
    send(0); send(1);

    // fill the block while the receiver holds off
    long_hold = 1;
    for (int i = 0; i < 6; i++) send(0);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 8; ph++) begin
      mode = $urandom_range(3);
      write_reg(rdp_pkg::REG_BOND, (mode == 0) ? 32'h0 : (mode == 1) ? 32'hFFFFFFFF
                : (mode == 2) ? $urandom : $urandom_range(32'h04000000));
      for (int r = rdp_pkg::REG_XX; r <= rdp_pkg::REG_ZZ; r++)
        write_reg(r[2:0], pick_cell((mode + r) % 4));
      case ($urandom_range(5))
        0: write_reg(rdp_pkg::REG_SEED, 32'h0);
        1: write_reg(rdp_pkg::REG_SEED, 32'h7FFFFFFF);
        default: write_reg(rdp_pkg::REG_SEED,
                           $urandom_range(32'h7FFFFFFE, 1) | ($urandom & 32'h80000000));
      endcase
      for (int i = 0; i < 215; i++) begin
        if ($urandom_range(40) == 0) burst = ~burst;
        send($urandom_range(15) == 0);
      end
      burst = 0;
      drain();
    end

    drain();
    if (errors == 0)
      $display("random_dimer_placer_top verification clean");
    else
      $display("random_dimer_placer_top verification failed");
    $finish;
  end
endmodule
